### design/sxc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxc_pkg
// Shared constants and types of the subarray xor counter: value and count
// widths, table depth, queue depth and the operation that goes from the
// front part to the back part.
// ----------------------------------------------------------------------------
package sxc_pkg;

	// widths of the item fields and of the configuration register
	localparam int ELEM_W   = 8;
	localparam int TARGET_W = 8;
	localparam int TOTAL_W  = 24;

	// value width that takes part in the xor, and the count table
	localparam int VALUE_BITS = 8;
	localparam int COUNT_W    = 13;
	localparam int TBL_DEPTH  = 1 << VALUE_BITS;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [COUNT_W-1:0]    count_t;
	typedef logic [TOTAL_W-1:0]    total_t;

	// one classified item: lookup address, bump address, self hit, last mark
	typedef struct packed {
		value_t look_addr;
		value_t bump_addr;
		logic   self_hit;
		logic   last;
	} op_t;

endpackage

### design/sxc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxc_ram
// Generic RAM with one write port and two read ports, registered read data
// that updates only on a read enable. A read at the address being written
// returns the old contents.
// ----------------------------------------------------------------------------
module sxc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// storage write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

### design/sxc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxc_front
// Accepts input items, folds each element into the running prefix xor and
// classifies it into a table operation for the back part. Holds the target
// register.
// ----------------------------------------------------------------------------
module sxc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sxc_pkg::TARGET_W-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sxc_pkg::ELEM_W-1:0]    in_elem,
	input  logic                          in_last,
	output logic                          push,
	output sxc_pkg::op_t                  push_op,
	input  logic                          q_full
);
	import sxc_pkg::*;

	logic [TARGET_W-1:0] target_q;
	value_t              prefix_q;
	value_t              prefix_nxt;
	value_t              tgt;

	// target register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_we) begin
			target_q <= cfg_wdata;
		end
	end

	// classify the item
	assign tgt                = target_q[VALUE_BITS-1:0];
	assign prefix_nxt         = prefix_q ^ in_elem[VALUE_BITS-1:0];
	assign in_ready           = !q_full;
	assign push               = in_valid && in_ready;
	assign push_op.look_addr  = prefix_nxt ^ tgt;
	assign push_op.bump_addr  = prefix_nxt;
	assign push_op.self_hit   = (prefix_nxt == tgt);
	assign push_op.last       = in_last;

	// running prefix, cleared after the last item of an array
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
		end else if (push) begin
			prefix_q <= in_last ? '0 : prefix_nxt;
		end
	end

endmodule

### design/sxc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxc_queue
// Short register queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module sxc_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  sxc_pkg::op_t push_op,
	output logic         full,
	output logic         not_empty,
	input  logic         pop,
	output sxc_pkg::op_t head_op
);
	import sxc_pkg::*;

	op_t               ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head_op   = ent_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### design/sxc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxc_back
// Carries out the table operations: reads the lookup and bump entries,
// adds the lookup count and the self hit to the running total, writes the bumped count back
// and drives the result register. Forwards the write in flight to the next
// read and clears the table through its valid bits after the last item.
// ----------------------------------------------------------------------------
module sxc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_not_empty,
	input  sxc_pkg::op_t                head_op,
	output logic                        pop,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [sxc_pkg::TOTAL_W-1:0] res_total,
	output logic                        res_last
);
	import sxc_pkg::*;

	// read stage
	logic     valid_s1;
	op_t      op_s1;
	logic     fwd_a_s1;
	logic     fwd_b_s1;
	logic     vld_a_s1;
	logic     vld_b_s1;
	count_t   fval_s1;

	// table valid bits, running total, result register
	logic [TBL_DEPTH-1:0] valid_q;
	total_t               total_q;
	logic                 res_valid_q;
	total_t               res_total_q;
	logic                 res_last_q;

	logic                 adv;
	logic                 wr_live;
	count_t               rd_a;
	count_t               rd_b;
	count_t               cnt_a;
	count_t               cnt_b;
	count_t               cnt_bumped;
	logic [TOTAL_W:0]     sum;
	total_t               total_nxt;

	// stage handshakes
	assign adv     = valid_s1 && (!res_valid_q || res_ready);
	assign pop     = q_not_empty && (!valid_s1 || adv);
	assign wr_live = adv && !op_s1.last;

	sxc_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (TBL_DEPTH)
	) u_tbl (
		.clk     (clk),
		.we      (adv),
		.waddr   (op_s1.bump_addr),
		.wdata   (cnt_bumped),
		.re      (pop),
		.raddr_a (head_op.look_addr),
		.raddr_b (head_op.bump_addr),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// counts seen by this item, with forwarding and cleared entries
	assign cnt_a = fwd_a_s1 ? fval_s1 : (vld_a_s1 ? rd_a : '0);
	assign cnt_b = fwd_b_s1 ? fval_s1 : (vld_b_s1 ? rd_b : '0);
	assign cnt_bumped = (&cnt_b) ? cnt_b : cnt_b + 1'b1;

	// saturating total
	assign sum       = {1'b0, total_q} + (TOTAL_W+1)'(cnt_a)
	                 + (TOTAL_W+1)'(op_s1.self_hit);
	assign total_nxt = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// read stage payload, forward flags sampled against the write in flight
	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1    <= head_op;
			fval_s1  <= cnt_bumped;
			fwd_a_s1 <= wr_live && (op_s1.bump_addr == head_op.look_addr);
			fwd_b_s1 <= wr_live && (op_s1.bump_addr == head_op.bump_addr);
			vld_a_s1 <= valid_q[head_op.look_addr] && !(adv && op_s1.last);
			vld_b_s1 <= valid_q[head_op.bump_addr] && !(adv && op_s1.last);
		end
	end

	// valid bits and running total, both cleared after the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
		end else if (adv) begin
			if (op_s1.last) begin
				valid_q <= '0;
				total_q <= '0;
			end else begin
				valid_q[op_s1.bump_addr] <= 1'b1;
				total_q                  <= total_nxt;
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res_total_q <= total_nxt;
			res_last_q  <= op_s1.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res_total = res_total_q;
	assign res_last  = res_last_q;

`ifndef ASSERT_OFF
	// a new read only enters when the read stage is free or moving on
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!valid_s1 || adv))
		else $error("read issued into a held stage");

	// the table is empty right after the last item of an array
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && op_s1.last) |=> (valid_q == '0 && total_q == '0))
		else $error("table not cleared after last item");

	// within an array the total never goes down
	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !op_s1.last) |=> (total_q >= $past(total_q)))
		else $error("running total decreased");
`endif

endmodule

### design/subarray_xor_count_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subarray_xor_count_top
// Counts, per array of streamed elements, the subarrays whose xor equals a
// configured target; one running total is returned per element.
// ----------------------------------------------------------------------------
//  channel  | direction | fields
//  s_axis   | in        | tdata[7:0] element, tlast last_element
//  m_axis   | out       | tdata[23:0] subarray_total, tlast final_result
//  cfg      | in        | cfg_wdata[7:0] target_xor, written when cfg_we
//
//  one item per cycle while the output is not stalled; an item's result
//  passes through the queue, the table read and then the result register.
//  the count table is a two-read one-write ram, read once per item; the write
//  of the item ahead is forwarded, so equal prefixes do not stall.
//  after the last item the table is emptied at once through its valid bits.
//  reset clears control, the prefix, the total and the valid bits.
//  a stalled output holds its item; the queue lets input keep flowing briefly.
// ----------------------------------------------------------------------------
module subarray_xor_count_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,     // target_xor
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] element
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [23:0] subarray_total
	output logic        m_axis_tlast
);
	import sxc_pkg::*;

	logic push;
	op_t  push_op;
	logic q_full;
	logic q_not_empty;
	logic pop;
	op_t  head_op;

	// front: accept and classify
	sxc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_elem   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.push      (push),
		.push_op   (push_op),
		.q_full    (q_full)
	);

	// decoupling queue
	sxc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (pop),
		.head_op   (head_op)
	);

	// back: table update and result
	sxc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head_op     (head_op),
		.pop         (pop),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res_total   (m_axis_tdata),
		.res_last    (m_axis_tlast)
	);

endmodule
